### hdl/cca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_pkg: shared types and constants of the calendar clock
// Field widths, reset date, step limit and the month-length table.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int STEP_W  = 17;

    localparam logic [STEP_W-1:0] SEC_MAX_STEP = 17'd86399;
    localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'd16383;

    localparam logic [SEC_W-1:0]   SECOND_RESET = 6'd0;
    localparam logic [MIN_W-1:0]   MINUTE_RESET = 6'd43;
    localparam logic [HOUR_W-1:0]  HOUR_RESET   = 5'd20;
    localparam logic [DAY_W-1:0]   DAY_RESET    = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_RESET  = 4'd7;
    localparam int                 YEAR_RESET_I = 2026;
    localparam logic [YEAR_W-1:0]  YEAR_RESET   = YEAR_W'(YEAR_RESET_I);
    // Year modulo 25 is tracked alongside the year for the century rule.
    localparam logic [4:0]         YMOD25_RESET = 5'(YEAR_RESET_I % 25);

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Time of day split from an advance count.
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } hms_t;

    // Days in a non-leap month; codes outside 1..12 read as 31.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] days;
        unique case (month)
            MONTH_FEB: days = 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: days = 5'd30;
            default:   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage : cca_pkg
`default_nettype wire

### hdl/calendar_clock_advance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_clock_advance: Gregorian date and time-of-day clock
// Adds a count of seconds per input word and returns the new date and time.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output side is ready, and
// returns one result word per input word from its result register. The
// advance count (clamped to 86399) is split into hours, minutes and seconds
// on entry; a single update stage then adds it to the stored time, performs
// at most one day rollover with the full leap-year rule, and loads the
// result register, which also holds the clock state. The year holds at 16383
// and tuser flags the word in which that happened. An input register in
// front of the update stage lets a new word be accepted while a result waits.
module calendar_clock_advance
    import cca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // add_seconds[16:0], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // out_second, out_minute, out_hour,
                                       // out_day, out_month, out_year
    output logic [0:0]  m_axis_tuser   // year_saturated
);

    localparam logic [16:0] RECIP_60   = 17'd69905;  // floor(2^22 / 60)
    localparam logic [16:0] RECIP_3600 = 17'd1165;   // floor(2^22 / 3600)

    // ---------------- entry split ----------------
    logic [STEP_W-1:0] secs;
    logic [33:0]       prod_60;
    logic [33:0]       prod_3600;
    logic [10:0]       q_est;
    logic [4:0]        h_est;
    logic [17:0]       rem_60;
    logic [17:0]       rem_3600;
    logic [10:0]       q_min;
    logic [4:0]        q_hour;
    logic [10:0]       min_wide;
    hms_t              split;

    always_comb
    begin
        secs      = (s_axis_tdata[16:0] > SEC_MAX_STEP) ? SEC_MAX_STEP : s_axis_tdata[16:0];
        prod_60   = 34'(secs) * 34'(RECIP_60);
        prod_3600 = 34'(secs) * 34'(RECIP_3600);
        q_est     = prod_60[32:22];
        h_est     = prod_3600[26:22];
        // The reciprocals round down, so each estimate is low by at most one.
        rem_60    = 18'(secs) - 18'(q_est) * 18'd60;
        rem_3600  = 18'(secs) - 18'(h_est) * 18'd3600;
        q_min     = (rem_60 >= 18'd60) ? q_est + 11'd1 : q_est;
        q_hour    = (rem_3600 >= 18'd3600) ? h_est + 5'd1 : h_est;
        min_wide  = q_min - 11'(q_hour) * 11'd60;
        split.second = (rem_60 >= 18'd60) ? 6'(rem_60 - 18'd60) : rem_60[5:0];
        split.minute = min_wide[5:0];
        split.hour   = q_hour;
    end

    // ---------------- handshake ----------------
    logic in_valid_reg;
    logic in_valid_next;
    hms_t in_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg <= split;
        end
    end

    // ---------------- calendar update ----------------
    logic [SEC_W-1:0]   second_reg, second_next;
    logic [MIN_W-1:0]   minute_reg, minute_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [4:0]         ymod25_reg, ymod25_next;
    logic               sat_reg, sat_next;

    logic [6:0]         sec_sum;
    logic [6:0]         min_sum;
    logic [5:0]         hour_sum;
    logic               sec_carry;
    logic               min_carry;
    logic               day_carry;
    logic               leap;
    logic [DAY_W-1:0]   dim;
    logic [DAY_W-1:0]   day_inc;
    logic [MONTH_W:0]   month_inc;
    logic               month_end;

    always_comb
    begin
        sec_sum   = 7'(second_reg) + 7'(in_reg.second);
        sec_carry = sec_sum >= 7'd60;
        min_sum   = 7'(minute_reg) + 7'(in_reg.minute) + 7'(sec_carry);
        min_carry = min_sum >= 7'd60;
        hour_sum  = 6'(hour_reg) + 6'(in_reg.hour) + 6'(min_carry);
        day_carry = hour_sum >= 6'd24;

        // Divisible by 400 means divisible by 16 and by 25.
        leap      = (year_reg[1:0] == 2'b00) &&
                    ((ymod25_reg != 5'd0) || (year_reg[3:0] == 4'd0));
        dim       = (month_reg == MONTH_FEB && leap) ? 5'd29 : month_days(month_reg);
        day_inc   = day_reg + 5'd1;
        month_end = (day_inc > dim) || (day_inc == 5'd0);
        month_inc = {1'b0, month_reg} + 5'd1;

        second_next = sec_carry ? 6'(sec_sum - 7'd60) : sec_sum[5:0];
        minute_next = min_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];
        hour_next   = day_carry ? 5'(hour_sum - 6'd24) : hour_sum[4:0];
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        ymod25_next = ymod25_reg;
        sat_next    = 1'b0;

        if (day_carry)
        begin
            if (!month_end)
            begin
                day_next = day_inc;
            end
            else
            begin
                day_next = 5'd1;
                if (month_inc > 5'(MONTH_DEC))
                begin
                    month_next = 4'd1;
                    if (year_reg == YEAR_MAX)
                    begin
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        year_next   = year_reg + 14'd1;
                        ymod25_next = (ymod25_reg == 5'd24) ? 5'd0 : ymod25_reg + 5'd1;
                    end
                end
                else
                begin
                    month_next = month_inc[MONTH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= SECOND_RESET;
            minute_reg <= MINUTE_RESET;
            hour_reg   <= HOUR_RESET;
            day_reg    <= DAY_RESET;
            month_reg  <= MONTH_RESET;
            year_reg   <= YEAR_RESET;
            ymod25_reg <= YMOD25_RESET;
            sat_reg    <= 1'b0;
        end
        else if (advance)
        begin
            second_reg <= second_next;
            minute_reg <= minute_next;
            hour_reg   <= hour_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            ymod25_reg <= ymod25_next;
            sat_reg    <= sat_next;
        end
    end

    // The clock state itself is the result word.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {year_reg, month_reg, day_reg, hour_reg, minute_reg, second_reg};
    assign m_axis_tuser  = sat_reg;

endmodule : calendar_clock_advance
`default_nettype wire

### hdl/cca_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cca_checker: port-level checks for the calendar clock
// Watches the result channel for held words and legal calendar values, and the input side for stalls.
// ----------------------------------------------------------------------------
module cca_checker
    import cca_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    logic [SEC_W-1:0]   o_second;
    logic [MIN_W-1:0]   o_minute;
    logic [HOUR_W-1:0]  o_hour;
    logic [DAY_W-1:0]   o_day;
    logic [MONTH_W-1:0] o_month;
    logic [YEAR_W-1:0]  o_year;

    assign o_second = m_axis_tdata[5:0];
    assign o_minute = m_axis_tdata[11:6];
    assign o_hour   = m_axis_tdata[16:12];
    assign o_day    = m_axis_tdata[21:17];
    assign o_month  = m_axis_tdata[25:22];
    assign o_year   = m_axis_tdata[39:26];

    // A stalled result word must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_second < 6'd60 && o_minute < 6'd60 && o_hour < 5'd24)
    else $error("time of day out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> o_day != 5'd0 && o_month != 4'd0 && o_month <= MONTH_DEC)
    else $error("date out of range");

    // A saturating rollover always lands on the first of January of the last year.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            o_year == YEAR_MAX && o_month == 4'd1 && o_day == 5'd1 && o_hour < 5'd24)
    else $error("saturation flag without a year-end rollover");

    // With no result waiting, the input register always drains or is empty,
    // so an offered word is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

endmodule : cca_checker

bind calendar_clock_advance cca_checker u_cca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### tb/calendar_clock_advance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_advance_tb: self-checking bench for the calendar clock
// Streams advance counts into the clock and checks every returned date and
// time against a behavioral calendar kept in step with the accepted words.
// Covers second, minute, hour and day carries, month and year ends, leap
// February, and oversized counts, under random gaps and output stalls.
// ----------------------------------------------------------------------------
module calendar_clock_advance_tb;
    import cca_pkg::*;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;

    typedef struct {
        logic [STEP_W-1:0] seconds;
        int unsigned       gap;
        bit                drain;
    } advance_item_t;

    // Packed in output order: tuser on top, then tdata from year down to second.
    typedef struct packed {
        logic              sat;
        logic [YEAR_W-1:0] year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } clock_reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // add_seconds[16:0], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // second, minute, hour, day, month, year
    logic [0:0]  m_axis_tuser;        // year_saturated

    advance_item_t  advance_q[$];
    clock_reading_t reading_q[$];

    logic [SEC_W-1:0]   now_second = SECOND_RESET;
    logic [MIN_W-1:0]   now_minute = MINUTE_RESET;
    logic [HOUR_W-1:0]  now_hour   = HOUR_RESET;
    logic [DAY_W-1:0]   now_day    = DAY_RESET;
    logic [MONTH_W-1:0] now_month  = MONTH_RESET;
    logic [YEAR_W-1:0]  now_year   = YEAR_RESET;

    // Month lengths by 4-bit month code; codes outside 1..12 read as 31.
    int unsigned month_length [0:15] =
        '{31, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 31, 31};

    int unsigned error_count = 0;
    int unsigned send_idle = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_calm = 0;
    advance_item_t send_item;
    clock_reading_t seen;

    calendar_clock_advance uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Moves the calendar forward by one accepted word and records the reading.
    task automatic advance_clock(input logic [STEP_W-1:0] request);
        int unsigned    step;
        int unsigned    total;
        int unsigned    carry;
        int unsigned    days;
        int unsigned    next_day;
        int unsigned    next_month;
        logic           leap;
        logic           sat;
        clock_reading_t reading;
        step = (request > SEC_MAX_STEP) ? SEC_MAX_STEP : request;
        sat = 1'b0;
        total = now_second + step;
        now_second = SEC_W'(total % 60);
        carry = total / 60;
        if (carry != 0)
        begin
            total = now_minute + carry;
            now_minute = MIN_W'(total % 60);
            carry = total / 60;
            if (carry != 0)
            begin
                total = now_hour + carry;
                now_hour = HOUR_W'(total % 24);
                if (total / 24 != 0)
                begin
                    leap = (now_year % 4 == 0) &&
                           ((now_year % 100 != 0) || (now_year % 400 == 0));
                    days = (now_month == MONTH_FEB && leap) ? 29 : month_length[now_month];
                    next_day = (now_day + 1) & 31;
                    if (next_day > days || next_day == 0)
                    begin
                        next_day = 1;
                        next_month = now_month + 1;
                        if (next_month > MONTH_DEC)
                        begin
                            next_month = MONTH_JAN;
                            if (now_year >= YEAR_MAX)
                                sat = 1'b1;
                            else
                                now_year = now_year + 1'b1;
                        end
                        now_month = MONTH_W'(next_month);
                    end
                    now_day = DAY_W'(next_day);
                end
            end
        end
        reading.sat    = sat;
        reading.year   = now_year;
        reading.month  = now_month;
        reading.day    = now_day;
        reading.hour   = now_hour;
        reading.minute = now_minute;
        reading.second = now_second;
        reading_q.push_back(reading);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            error_count++;
            if (error_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    task automatic queue_advance(input int unsigned secs, input int unsigned gap,
                                 input bit drain);
        advance_item_t item;
        item.seconds = STEP_W'(secs);
        item.gap     = gap;
        item.drain   = drain;
        advance_q.push_back(item);
    endtask

    // Sender: each word waits its own idle count, and a drain word waits
    // until every outstanding reading has come back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_idle = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_clock(s_axis_tdata[STEP_W-1:0]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (advance_q.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (send_idle < advance_q[0].gap)
                begin
                    send_idle++;
                    s_axis_tvalid <= 1'b0;
                end
                else if (advance_q[0].drain && reading_q.size() != 0)
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    send_item = advance_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'b0, send_item.seconds};
                    send_idle = 0;
                end
            end
        end
    end

    // Receiver: checks each word, then draws a stall, with occasional calm runs.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait = 0;
            recv_calm = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = clock_reading_t'({m_axis_tuser, m_axis_tdata});
                if (reading_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected word %h", $realtime, seen);
                end
                else
                begin
                    check_field("second", reading_q[0].second, seen.second);
                    check_field("minute", reading_q[0].minute, seen.minute);
                    check_field("hour", reading_q[0].hour, seen.hour);
                    check_field("day", reading_q[0].day, seen.day);
                    check_field("month", reading_q[0].month, seen.month);
                    check_field("year", reading_q[0].year, seen.year);
                    check_field("year_saturated", reading_q[0].sat, seen.sat);
                    void'(reading_q.pop_front());
                end
                if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_wait = 0;
                end
                else
                begin
                    recv_wait = $urandom_range(0, 14);
                    if ($urandom_range(0, 59) == 0)
                        recv_calm = 120;
                end
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // The year hold at 16383 lies millions of days past the reset date, so
    // no run of this length reaches it; the calendar above still covers it.
    initial
    begin
        int unsigned directed [14] = '{0, 1, 59, 60, 61, 3599, 3600, 43200, 86340,
                                       86399, 86400, 65536, 100000, 131071};
        int unsigned idx;
        int unsigned pick;
        int unsigned secs;
        bit          quiet;
        quiet = 1'b0;
        for (idx = 0; idx < 14; idx++)
            queue_advance(directed[idx], $urandom_range(0, 14), 1'b0);
        // Mostly near-day steps so the date walks through month ends,
        // year ends and a leap February.
        for (idx = 0; idx < 1900; idx++)
        begin
            if (idx % 150 == 0)
                quiet = ((idx / 150) % 2 == 1);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                secs = $urandom_range(80000, 86399);
            else if (pick < 65)
                secs = $urandom_range(0, 150);
            else if (pick < 85)
                secs = $urandom_range(0, 86399);
            else if (pick < 95)
                secs = $urandom_range(86400, 131071);
            else
                secs = $urandom_range(0, 131071);
            queue_advance(secs, quiet ? 0 : $urandom_range(0, 14), idx % 400 == 0);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (advance_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (reading_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0 && reading_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
